/* rtl/tlcq_pkg.sv */
// ----------------------------------------------------------------------------
// tlcq_pkg
// Shared types and constants for the chain-walk common-ancestor unit.
// ----------------------------------------------------------------------------
package tlcq_pkg;

	localparam int NODE_W         = 10;
	localparam int DEPTH_W        = 11;
	localparam int TABLE_DEPTH    = 1 << NODE_W;
	localparam int DEF_NODE_COUNT = 1024;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic [NODE_W-1:0]  parent;
		logic [DEPTH_W-1:0] depth;
		logic [NODE_W-1:0]  head;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/tlcq_ram.sv */
// ----------------------------------------------------------------------------
// tlcq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tlcq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/tree_lca_chain_query_top.sv */
// ----------------------------------------------------------------------------
// tree_lca_chain_query_top
// Lowest common ancestor over a heavy-chain decomposed tree. Node entries
// (parent, depth, chain head) live in two mirrored RAMs so that both query
// nodes are read in the same cycle.
//
//  channel  | handshake           | beat
//  ---------+---------------------+------------------------------------------
//  in       | in_valid / in_stall | opcode, first_node, second_node, entry_*
//  out      | out_valid/out_stall | ancestor, walk_error
//
// A write beat is taken while idle. A query stalls the input until its answer
// is registered for output; every chain jump costs one RAM read of the chain
// heads and one RAM read of the new nodes.
// The walk stops with walk_error after NODE_COUNT jumps.
// Reset clears the state and output registers; table contents are undefined until written.
// A stalled output holds its beat; the walk waits for a free output register.
// ----------------------------------------------------------------------------
module tree_lca_chain_query_top
	import tlcq_pkg::*;
#(
	parameter int NODE_COUNT = DEF_NODE_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [NODE_W-1:0]  first_node,
	input  logic [NODE_W-1:0]  second_node,
	input  logic [NODE_W-1:0]  entry_parent,
	input  logic [DEPTH_W-1:0] entry_depth,
	input  logic [NODE_W-1:0]  entry_chain_head,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [NODE_W-1:0]  ancestor,
	output logic               walk_error
);

	localparam int JW = $clog2(NODE_COUNT + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_NODE, ST_HEAD, ST_DONE} state_t;

	state_t             state_q;
	logic [NODE_W-1:0]  u_q, v_q, ans_q;
	logic               err_q;
	logic [JW-1:0]      jumps_q;
	logic               out_valid_q, walk_error_q;
	logic [NODE_W-1:0]  ancestor_q;

	logic               in_acc, we, out_free;
	entry_t             wr_ent, ent_a, ent_b;
	logic [ENTRY_W-1:0] rdata_a, rdata_b;
	logic [NODE_W-1:0]  raddr_a, raddr_b, nu, nv;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign we        = in_acc && (opcode == OP_WRITE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign ancestor   = ancestor_q;
	assign walk_error = walk_error_q;

	assign wr_ent = '{parent: entry_parent, depth: entry_depth, head: entry_chain_head};
	assign ent_a  = entry_t'(rdata_a);
	assign ent_b  = entry_t'(rdata_b);

	// heads' entries are on the read ports in ST_HEAD; deeper head jumps, tie moves v
	always_comb begin
		nu = u_q;
		nv = v_q;
		if (ent_a.depth > ent_b.depth) begin
			nu = ent_a.parent;
		end else begin
			nv = ent_b.parent;
		end
	end

	always_comb begin
		raddr_a = u_q;
		raddr_b = v_q;
		unique case (state_q)
			ST_IDLE: begin
				raddr_a = first_node;
				raddr_b = second_node;
			end
			ST_NODE: begin
				raddr_a = ent_a.head;
				raddr_b = ent_b.head;
			end
			ST_HEAD: begin
				raddr_a = nu;
				raddr_b = nv;
			end
			default: begin
			end
		endcase
	end

	tlcq_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we),
		.waddr (first_node),
		.wdata (wr_ent),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	tlcq_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we),
		.waddr (first_node),
		.wdata (wr_ent),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			jumps_q      <= '0;
			u_q          <= '0;
			v_q          <= '0;
			ans_q        <= '0;
			err_q        <= 1'b0;
			ancestor_q   <= '0;
			walk_error_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (opcode == OP_QUERY)) begin
						u_q     <= first_node;
						v_q     <= second_node;
						jumps_q <= '0;
						state_q <= ST_NODE;
					end
				end
				ST_NODE: begin
					if (ent_a.head == ent_b.head) begin
						ans_q   <= (ent_a.depth > ent_b.depth) ? v_q : u_q;
						err_q   <= 1'b0;
						state_q <= ST_DONE;
					end else if (jumps_q >= JW'(NODE_COUNT)) begin
						ans_q   <= '0;
						err_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					u_q     <= nu;
					v_q     <= nv;
					jumps_q <= jumps_q + 1'b1;
					state_q <= ST_NODE;
				end
				ST_DONE: begin
					if (out_free) begin
						ancestor_q   <= ans_q;
						walk_error_q <= err_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/tlcq_chk.sv */
// ----------------------------------------------------------------------------
// tlcq_chk
// Port-level checks for the chain-walk common-ancestor unit.
// ----------------------------------------------------------------------------
module tlcq_chk
	import tlcq_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               opcode,
	input logic               out_valid,
	input logic               out_stall,
	input logic [NODE_W-1:0]  ancestor,
	input logic               walk_error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ancestor) && $stable(walk_error))
		else $error("stalled output beat changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && walk_error |-> ancestor == '0)
		else $error("failed walk reports nonzero ancestor");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (opcode == OP_WRITE) && !out_valid |=> !out_valid)
		else $error("write beat produced a result");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (opcode == OP_QUERY) |=> in_stall)
		else $error("input taken while a query is walking");

endmodule

bind tree_lca_chain_query_top tlcq_chk u_tlcq_chk (.*);

/* tb/sv/tree_lca_chain_query_checker.sv */
// ----------------------------------------------------------------------------
// tree_lca_chain_query_checker
// Passive monitor for the chain-walk common-ancestor unit. Mirrors the node
// tables from accepted write beats, walks the chains for each accepted query
// beat, queues the expected answer and compares every output beat with the
// oldest queued answer, field by field.
// ----------------------------------------------------------------------------
module tree_lca_chain_query_checker
	import tlcq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               opcode,
	input  logic [NODE_W-1:0]  first_node,
	input  logic [NODE_W-1:0]  second_node,
	input  logic [NODE_W-1:0]  entry_parent,
	input  logic [DEPTH_W-1:0] entry_depth,
	input  logic [NODE_W-1:0]  entry_chain_head,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [NODE_W-1:0]  ancestor,
	input  logic               walk_error,
	output int                 mismatch_count,
	output int                 results_pending
);

	localparam int WALK_LIMIT = DEF_NODE_COUNT;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic              fault;
	} lca_answer_t;

	bit [NODE_W-1:0]  parent_of_node [TABLE_DEPTH];
	bit [DEPTH_W-1:0] depth_of_node  [TABLE_DEPTH];
	bit [NODE_W-1:0]  head_of_node   [TABLE_DEPTH];

	lca_answer_t answers_due [$];
	int          fail_total = 0;

	function automatic lca_answer_t walk_chains(input logic [NODE_W-1:0] u_start,
		input logic [NODE_W-1:0] v_start);
		lca_answer_t       res;
		logic [NODE_W-1:0] u;
		logic [NODE_W-1:0] v;
		int                hops;
		u         = u_start;
		v         = v_start;
		hops      = 0;
		res.node  = '0;
		res.fault = 1'b0;
		while (head_of_node[u] != head_of_node[v]) begin
			if (hops >= WALK_LIMIT) begin
				res.fault = 1'b1;
				return res;
			end
			// deeper head jumps; on a tie the second node moves
			if (depth_of_node[head_of_node[u]] > depth_of_node[head_of_node[v]])
				u = parent_of_node[head_of_node[u]];
			else
				v = parent_of_node[head_of_node[v]];
			hops++;
		end
		res.node = (depth_of_node[u] > depth_of_node[v]) ? v : u;
		return res;
	endfunction

	always @(posedge clk) begin : monitor
		lca_answer_t due;
		if (arst_n) begin
			// output side first so a beat can never match an answer queued this edge
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					$error("result beat with no query outstanding: ancestor %0d walk_error %0d",
						ancestor, walk_error);
					fail_total++;
				end else begin
					due = answers_due.pop_front();
					if (ancestor !== due.node) begin
						$error("ancestor: expected %0d, got %0d", due.node, ancestor);
						fail_total++;
					end
					if (walk_error !== due.fault) begin
						$error("walk_error: expected %0d, got %0d", due.fault, walk_error);
						fail_total++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (opcode == OP_WRITE) begin
					parent_of_node[first_node] = entry_parent;
					depth_of_node[first_node]  = entry_depth;
					head_of_node[first_node]   = entry_chain_head;
				end else begin
					answers_due = {answers_due, walk_chains(first_node, second_node)};
				end
			end
		end
		mismatch_count  <= fail_total;
		results_pending <= answers_due.size();
	end

endmodule

/* tb/sv/tree_lca_chain_query_top_tb.sv */
// ----------------------------------------------------------------------------
// tree_lca_chain_query_top_tb
// Stimulus and verdict for the chain-walk common-ancestor unit. A directed
// block covers field extremes, same-chain answers, head-depth ties, equal
// depths and runaway walks; then random chain-decomposed trees are loaded and
// queried, with a few corrupting writes and stray queries mixed in. Sender
// gaps and receiver stalls change from tree to tree. Checking is done by the
// checker instance.
// ----------------------------------------------------------------------------
module tree_lca_chain_query_top_tb;
	import tlcq_pkg::*;

	localparam int ITEM_TARGET = 800;
	localparam int MAX_TREE    = 40;
	localparam int DRAIN_WAIT  = 64;
	localparam int RUN_LIMIT   = 8 * 20000000;

	logic               clk              = 1'b0;
	logic               arst_n           = 1'b0;
	logic               in_valid         = 1'b0;
	logic               in_stall;
	logic               opcode           = OP_WRITE;
	logic [NODE_W-1:0]  first_node       = '0;
	logic [NODE_W-1:0]  second_node      = '0;
	logic [NODE_W-1:0]  entry_parent     = '0;
	logic [DEPTH_W-1:0] entry_depth      = '0;
	logic [NODE_W-1:0]  entry_chain_head = '0;
	logic               out_valid;
	logic               out_stall        = 1'b0;
	logic [NODE_W-1:0]  ancestor;
	logic               walk_error;

	int mismatch_count;
	int results_pending;
	int idle_pct    = 0;
	int stall_pct   = 0;
	int items_sent  = 0;

	// nodes holding a table entry; every stored parent and head is one of them
	bit                written_map [TABLE_DEPTH];
	logic [NODE_W-1:0] written_list [$];

	tree_lca_chain_query_top u_top (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .first_node, .second_node,
		.entry_parent, .entry_depth, .entry_chain_head, .out_valid, .out_stall,
		.ancestor, .walk_error
	);

	tree_lca_chain_query_checker u_checker (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .first_node, .second_node,
		.entry_parent, .entry_depth, .entry_chain_head, .out_valid, .out_stall,
		.ancestor, .walk_error, .mismatch_count, .results_pending
	);

	always #4 clk = ~clk;

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	initial begin
		#(RUN_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	task automatic send_beat(input logic op, input logic [NODE_W-1:0] a,
		input logic [NODE_W-1:0] b, input logic [NODE_W-1:0] par,
		input logic [DEPTH_W-1:0] dep, input logic [NODE_W-1:0] head);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		opcode           <= op;
		first_node       <= a;
		second_node      <= b;
		entry_parent     <= par;
		entry_depth      <= dep;
		entry_chain_head <= head;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic write_node(input logic [NODE_W-1:0] node,
		input logic [NODE_W-1:0] par, input logic [DEPTH_W-1:0] dep,
		input logic [NODE_W-1:0] head);
		send_beat(OP_WRITE, node, NODE_W'($urandom), par, dep, head);
		if (!written_map[node]) begin
			written_map[node] = 1'b1;
			written_list = {written_list, node};
		end
	endtask

	task automatic ask_ancestor(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
		send_beat(OP_QUERY, a, b, NODE_W'($urandom), DEPTH_W'($urandom_range(0, 1024)),
			NODE_W'($urandom));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [NODE_W-1:0] any_written();
		return written_list[$urandom_range(0, written_list.size() - 1)];
	endfunction

	initial begin
		int                phase;
		int                tree_size;
		int                top_level;
		int                base;
		int                pick;
		int                n_query;
		int                lo;
		int                lvl        [MAX_TREE];
		int                par_idx    [MAX_TREE];
		int                head_idx   [MAX_TREE];
		bit                chain_used [MAX_TREE];
		logic [NODE_W-1:0] label      [MAX_TREE];
		bit                taken      [TABLE_DEPTH];

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// root 0 with 1023 and 200 on its chain, a side chain under 1023, and two sibling chains
		write_node(10'd0,   10'd0,   11'd1, 10'd0);
		write_node(10'd1023, 10'd0,  11'd2, 10'd0);
		write_node(10'd512, 10'd1023, 11'd3, 10'd512);
		write_node(10'd341, 10'd512, 11'd4, 10'd512);
		write_node(10'd682, 10'd0,   11'd2, 10'd682);
		write_node(10'd100, 10'd0,   11'd2, 10'd100);
		write_node(10'd200, 10'd0,   11'd2, 10'd0);
		// two self-looping chains: the walk never meets
		write_node(10'd300, 10'd300, 11'd1024, 10'd300);
		write_node(10'd301, 10'd301, 11'd0,    10'd301);
		ask_ancestor(10'd0,    10'd0);
		ask_ancestor(10'd1023, 10'd0);
		ask_ancestor(10'd0,    10'd1023);
		ask_ancestor(10'd341,  10'd682);
		ask_ancestor(10'd341,  10'd1023);
		ask_ancestor(10'd512,  10'd341);
		ask_ancestor(10'd682,  10'd100);
		ask_ancestor(10'd200,  10'd1023);
		ask_ancestor(10'd1023, 10'd200);
		ask_ancestor(10'd300,  10'd301);
		ask_ancestor(10'd301,  10'd300);
		ask_ancestor(10'd300,  10'd341);
		drain_results();

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 78; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 78; end
				default: begin idle_pct = 17; stall_pct = 17; end
			endcase

			tree_size = $urandom_range(4, MAX_TREE);
			foreach (taken[k]) taken[k] = 1'b0;
			for (int i = 0; i < tree_size; i++) begin
				do pick = $urandom_range(0, TABLE_DEPTH - 1); while (taken[pick]);
				taken[pick]   = 1'b1;
				label[i]      = NODE_W'(pick);
				chain_used[i] = 1'b0;
			end
			lvl[0]      = 1;
			par_idx[0]  = 0;
			head_idx[0] = 0;
			top_level   = 1;
			for (int i = 1; i < tree_size; i++) begin
				lo         = ($urandom_range(1) && i > 3) ? i - 3 : 0;
				par_idx[i] = $urandom_range(lo, i - 1);
				lvl[i]     = lvl[par_idx[i]] + 1;
				if (lvl[i] > top_level)
					top_level = lvl[i];
				if (!chain_used[par_idx[i]] && $urandom_range(3) != 0) begin
					chain_used[par_idx[i]] = 1'b1;
					head_idx[i] = head_idx[par_idx[i]];
				end else begin
					head_idx[i] = i;
				end
			end
			base = $urandom_range(0, 1024 - top_level);
			for (int i = 0; i < tree_size; i++)
				write_node(label[i], (i == 0) ? 10'd0 : label[par_idx[i]],
					DEPTH_W'(base + lvl[i]), label[head_idx[i]]);

			n_query = $urandom_range(tree_size, 2 * tree_size);
			for (int q = 0; q < n_query; q++)
				ask_ancestor(label[$urandom_range(0, tree_size - 1)],
					label[$urandom_range(0, tree_size - 1)]);

			if ($urandom_range(2) == 0)
				write_node(any_written(), any_written(), DEPTH_W'($urandom_range(0, 1024)),
					any_written());
			repeat ($urandom_range(1, 2))
				ask_ancestor(any_written(), any_written());

			drain_results();
			phase++;
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (results_pending != 0)
			$error("%0d expected results never arrived", results_pending);
		if (mismatch_count == 0 && results_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* tree_lca_chain_query_top.f */
rtl/tlcq_pkg.sv
rtl/tlcq_ram.sv
rtl/tree_lca_chain_query_top.sv
rtl/tlcq_chk.sv
tb/sv/tree_lca_chain_query_checker.sv
tb/sv/tree_lca_chain_query_top_tb.sv
